@@ sv/hard_sphere_particle_step_top_macros.svh @@
// Assertion macros for the hard sphere step block checker.
// Used by hsps_chk only; expects clk and arst_n in scope.
`ifndef HARD_SPHERE_PARTICLE_STEP_TOP_MACROS_SVH
`define HARD_SPHERE_PARTICLE_STEP_TOP_MACROS_SVH
// consequent in the cycle after the antecedent
`define HSPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsps: next-cycle check failed");
// consequent in the same cycle as the antecedent
`define HSPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsps: same-cycle check failed");
`endif

@@ sv/hsps_pkg.sv @@
// Shared types, constants and helpers for the hard sphere step block.
// No dependencies; used by hsps_div, hsps_ctrl, the top level and the testbench.
`timescale 1ns / 1ps
package hsps_pkg;
	localparam int MAX_PARTICLES_DEF = 64;

	// op codes carried in s_tuser
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_IN_USE = 3'd0;
	localparam logic [2:0] CFG_BOX_W  = 3'd1;
	localparam logic [2:0] CFG_BOX_H  = 3'd2;
	localparam logic [2:0] CFG_BOX_D  = 3'd3;
	localparam logic [2:0] CFG_RADIUS = 3'd4;
	localparam logic [2:0] CFG_DT     = 3'd5;

	// beat layout
	localparam int TD_IN_W  = 200;
	localparam int TD_OUT_W = 232;
	localparam int IDX_LSB  = 0;
	localparam int POS_LSB  = 6;
	localparam int VEL_LSB  = 102;
	localparam int COLL_LSB = 198;
	localparam int VEC_W    = 96;

	// divider sizes
	localparam int NUM_W = 98;
	localparam int DEN_W = 64;
	localparam int QUO_W = 41;

	typedef struct packed {
		logic [6:0]  in_use;
		logic [30:0] box_w;
		logic [30:0] box_h;
		logic [30:0] box_d;
		logic [30:0] radius;
		logic [31:0] dt;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	function automatic logic [31:0] sat32(input logic signed [49:0] v);
		logic [31:0] r;
		if (v > 50'sd2147483647) r = 32'h7fff_ffff;
		else if (v < -50'sd2147483648) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic [32:0] t;
		t = v[32] ? (~v + 33'd1) : v;
		return t[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction
endpackage

@@ sv/hsps_ram.sv @@
// Generic simple dual port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module hsps_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

@@ sv/hsps_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient clamped to 2^40.
// Depends on hsps_pkg.
`timescale 1ns / 1ps
module hsps_div (
	input  logic               clk,
	input  logic               arst_n,
	input  hsps_pkg::div_req_t req,
	output hsps_pkg::div_rsp_t rsp
);
	localparam int NW = hsps_pkg::NUM_W;
	localparam int DW = hsps_pkg::DEN_W;
	localparam int QW = hsps_pkg::QUO_W;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic          ovf_q;
	logic [DW:0]   sh;
	logic [DW:0]   diff;
	logic          ge;

	assign sh   = {rem_q, num_q[NW-1]};
	assign ge   = sh >= {1'b0, den_q};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
			ovf_q <= ovf_q | quo_q[QW-1];
		end
	end

	// anything above 2^40 reads as 2^40
	always_comb begin
		rsp.busy = busy_q;
		if (ovf_q || (quo_q[QW-1] && (|quo_q[QW-2:0]))) rsp.quo = {1'b1, {(QW-1){1'b0}}};
		else rsp.quo = quo_q;
	end
endmodule

@@ sv/hsps_ctrl.sv @@
// Sequencer and datapath: item decode, motion/wall pass, pair pass, result register.
// Depends on hsps_pkg; drives the two particle RAMs and the divider.
`timescale 1ns / 1ps
module hsps_ctrl #(
	parameter int MAX_PARTICLES = hsps_pkg::MAX_PARTICLES_DEF,
	localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1,
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hsps_pkg::cfg_t                cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [1:0]                    s_tuser,
	input  logic [hsps_pkg::TD_IN_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hsps_pkg::TD_OUT_W-1:0] m_tdata,
	output logic                          pos_we,
	output logic                          vel_we,
	output logic [IDX_W-1:0]              wr_addr,
	output logic [hsps_pkg::VEC_W-1:0]    pos_wdata,
	output logic [hsps_pkg::VEC_W-1:0]    vel_wdata,
	output logic                          rd_en,
	output logic [IDX_W-1:0]              rd_addr,
	input  logic [hsps_pkg::VEC_W-1:0]    pos_rdata,
	input  logic [hsps_pkg::VEC_W-1:0]    vel_rdata,
	output hsps_pkg::div_req_t            div_req,
	input  hsps_pkg::div_rsp_t            div_rsp
);
	localparam int XW = ((IDX_W > 6) ? IDX_W : 6) + 1;
	localparam int UW = ((CNT_W > 7) ? CNT_W : 7) + 1;
	localparam int PL = hsps_pkg::POS_LSB;
	localparam int VL = hsps_pkg::VEL_LSB;
	localparam int CL = hsps_pkg::COLL_LSB;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DONE, ST_DEN, ST_DEN2,
		ST_M_RD, ST_M_MUL, ST_M_ADD, ST_M_WR,
		ST_P_LDN, ST_P_LAT, ST_P_RDM, ST_P_DIF, ST_P_SQ, ST_P_SQA, ST_P_CMP,
		ST_P_DOT, ST_P_DOTA, ST_P_MAG, ST_P_MLO, ST_P_MHI, ST_P_SUM,
		ST_P_DIVW, ST_P_UPD, ST_P_WRM, ST_P_NEXT
	} state_t;

	state_t state_q;
	logic [1:0]  op_q;
	logic        ok_q;
	logic [5:0]  idx_q;
	logic [hsps_pkg::TD_IN_W-1:0] sdata_q;
	logic        m_valid_q;
	logic [hsps_pkg::TD_OUT_W-1:0] m_data_q;
	logic [31:0] coll_q;
	logic [CNT_W-1:0] count_q, i_q, j_q;
	logic [1:0]  k_q;
	logic [63:0] den_q, dist_q, lo_q;
	logic [65:0] mul_p_q, dmag_q;
	logic [66:0] dot_q;
	logic        dneg_q;
	logic [2:0][31:0] npos_q, pn_pos_q, pn_vel_q, vm_q, ad_q, adv_q;
	logic [2:0]  dn_q, dvn_q;

	logic [33:0] mul_a;
	logic [31:0] mul_b;
	logic        accept;
	logic [XW-1:0] idx_x;
	logic        idx_ok;
	logic [UW-1:0] use_x, max_x, cnt_u;
	logic [2:0][31:0] rpos, rvel, flip_vel;
	logic [2:0][30:0] box;
	logic [31:0] cur_pos, cur_vel, twor;
	logic signed [49:0] adv_sum, pn_new, vm_new, delta50;
	logic [47:0] mot_sh;
	logic        j_last, i_last, i_end;
	logic [hsps_pkg::TD_OUT_W-1:0] res;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign idx_x    = XW'(s_tdata[5:0]);
	assign idx_ok   = idx_x < XW'(MAX_PARTICLES);
	assign use_x    = UW'(cfg.in_use);
	assign max_x    = UW'(MAX_PARTICLES);
	assign cnt_u    = (use_x > max_x) ? max_x : use_x;
	assign rpos     = pos_rdata;
	assign rvel     = vel_rdata;
	assign box      = {cfg.box_d, cfg.box_h, cfg.box_w};
	assign twor     = {cfg.radius, 1'b0};
	assign cur_pos  = rpos[k_q];
	assign cur_vel  = rvel[k_q];
	assign j_last   = ({1'b0, j_q} + (CNT_W+1)'(1)) == {1'b0, count_q};
	assign i_last   = ({1'b0, i_q} + (CNT_W+1)'(1)) == {1'b0, count_q};
	assign i_end    = ({1'b0, i_q} + (CNT_W+1)'(2)) == {1'b0, count_q};

	// motion: pos + trunc(vel*dt/65536), saturated
	always_comb begin
		mot_sh  = mul_p_q[63:16];
		adv_sum = $signed({{18{cur_pos[31]}}, cur_pos}) +
			(cur_vel[31] ? -$signed({2'b0, mot_sh}) : $signed({2'b0, mot_sh}));
	end

	// wall reflection on the freshly moved position
	always_comb begin
		logic [31:0] half;
		for (int k = 0; k < 3; k++) begin
			half = {2'b0, box[k][30:1]};
			if ($signed(npos_q[k]) > $signed(half) || $signed(npos_q[k]) < -$signed(half))
				flip_vel[k] = (rvel[k] == 32'h8000_0000) ? 32'h7fff_ffff : (~rvel[k] + 32'd1);
			else
				flip_vel[k] = rvel[k];
		end
	end

	// velocity exchange for one axis
	always_comb begin
		delta50 = $signed({9'b0, div_rsp.quo});
		if (dneg_q != dn_q[k_q]) delta50 = -delta50;
		pn_new = $signed({{18{pn_vel_q[k_q][31]}}, pn_vel_q[k_q]}) - delta50;
		vm_new = $signed({{18{vm_q[k_q][31]}}, vm_q[k_q]}) + delta50;
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DEN: begin
				mul_a = {2'b0, twor};
				mul_b = twor;
			end
			ST_M_MUL: begin
				mul_a = {2'b0, hsps_pkg::mag32(cur_vel)};
				mul_b = cfg.dt;
			end
			ST_P_SQ: begin
				mul_a = {2'b0, ad_q[k_q]};
				mul_b = ad_q[k_q];
			end
			ST_P_DOT: begin
				mul_a = {2'b0, adv_q[k_q]};
				mul_b = ad_q[k_q];
			end
			ST_P_MLO: begin
				mul_a = {2'b0, dmag_q[31:0]};
				mul_b = ad_q[k_q];
			end
			ST_P_MHI: begin
				mul_a = dmag_q[65:32];
				mul_b = ad_q[k_q];
			end
			default: ;
		endcase
	end

	// RAM and divider control
	always_comb begin
		pos_we    = 1'b0;
		vel_we    = 1'b0;
		wr_addr   = i_q[IDX_W-1:0];
		pos_wdata = npos_q;
		vel_wdata = flip_vel;
		rd_en     = 1'b0;
		rd_addr   = i_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				wr_addr   = idx_x[IDX_W-1:0];
				rd_addr   = idx_x[IDX_W-1:0];
				pos_wdata = s_tdata[PL +: hsps_pkg::VEC_W];
				vel_wdata = s_tdata[VL +: hsps_pkg::VEC_W];
				if (accept && idx_ok && s_tuser == hsps_pkg::OP_WRITE) begin
					pos_we = 1'b1;
					vel_we = 1'b1;
				end
				if (accept && idx_ok && s_tuser == hsps_pkg::OP_READ) rd_en = 1'b1;
			end
			ST_M_RD, ST_P_LDN: rd_en = 1'b1;
			ST_M_WR: begin
				pos_we = 1'b1;
				vel_we = 1'b1;
			end
			ST_P_RDM: begin
				rd_en   = 1'b1;
				rd_addr = j_q[IDX_W-1:0];
			end
			ST_P_WRM: begin
				vel_we    = 1'b1;
				wr_addr   = j_q[IDX_W-1:0];
				vel_wdata = vm_q;
			end
			ST_P_NEXT: begin
				vel_we    = j_last;
				vel_wdata = pn_vel_q;
			end
			default: ;
		endcase
		div_req.start = (state_q == ST_P_SUM);
		div_req.num   = {34'b0, lo_q} + {mul_p_q, 32'b0};
		div_req.den   = den_q;
	end

	// result beat
	always_comb begin
		res = '0;
		res[CL +: 32] = coll_q;
		if (op_q == hsps_pkg::OP_WRITE || op_q == hsps_pkg::OP_READ) res[5:0] = idx_q;
		if (ok_q && op_q == hsps_pkg::OP_WRITE) res[PL +: 192] = sdata_q[PL +: 192];
		if (ok_q && op_q == hsps_pkg::OP_READ) res[PL +: 192] = {vel_rdata, pos_rdata};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			coll_q    <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			count_q   <= '0;
		end else begin
			if (m_valid_q && m_tready && state_q != ST_DONE) m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (s_tuser == hsps_pkg::OP_STEP) ? ST_DEN : ST_DONE;
						count_q <= cnt_u[CNT_W-1:0];
					end
				end
				ST_DEN: state_q <= ST_DEN2;
				ST_DEN2: begin
					i_q     <= '0;
					state_q <= (count_q == '0) ? ST_DONE : ST_M_RD;
				end
				ST_M_RD: begin
					k_q     <= '0;
					state_q <= ST_M_MUL;
				end
				ST_M_MUL: state_q <= ST_M_ADD;
				ST_M_ADD: begin
					k_q     <= k_q + 2'd1;
					state_q <= (k_q == 2'd2) ? ST_M_WR : ST_M_MUL;
				end
				ST_M_WR: begin
					if (i_last) begin
						i_q     <= '0;
						state_q <= (count_q >= CNT_W'(2)) ? ST_P_LDN : ST_DONE;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_M_RD;
					end
				end
				ST_P_LDN: state_q <= ST_P_LAT;
				ST_P_LAT: begin
					j_q     <= i_q + CNT_W'(1);
					state_q <= ST_P_RDM;
				end
				ST_P_RDM: state_q <= ST_P_DIF;
				ST_P_DIF: begin
					k_q     <= '0;
					state_q <= ST_P_SQ;
				end
				ST_P_SQ: state_q <= ST_P_SQA;
				ST_P_SQA: begin
					k_q     <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					state_q <= (k_q == 2'd2) ? ST_P_CMP : ST_P_SQ;
				end
				ST_P_CMP: state_q <= (dist_q < den_q) ? ST_P_DOT : ST_P_NEXT;
				ST_P_DOT: state_q <= ST_P_DOTA;
				ST_P_DOTA: begin
					k_q     <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					state_q <= (k_q == 2'd2) ? ST_P_MAG : ST_P_DOT;
				end
				ST_P_MAG: state_q <= ST_P_MLO;
				ST_P_MLO: state_q <= ST_P_MHI;
				ST_P_MHI: state_q <= ST_P_SUM;
				ST_P_SUM: state_q <= ST_P_DIVW;
				ST_P_DIVW: if (!div_rsp.busy) state_q <= ST_P_UPD;
				ST_P_UPD: begin
					k_q     <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					state_q <= (k_q == 2'd2) ? ST_P_WRM : ST_P_MLO;
				end
				ST_P_WRM: begin
					coll_q  <= coll_q + 32'd1;
					state_q <= ST_P_NEXT;
				end
				ST_P_NEXT: begin
					if (j_last) begin
						if (i_end) state_q <= ST_DONE;
						else begin
							i_q     <= i_q + CNT_W'(1);
							state_q <= ST_P_LDN;
						end
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= ST_P_RDM;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		if (accept) begin
			op_q    <= s_tuser;
			ok_q    <= idx_ok;
			idx_q   <= s_tdata[5:0];
			sdata_q <= s_tdata;
		end
		if (state_q == ST_DONE && (!m_valid_q || m_tready)) m_data_q <= res;
		case (state_q)
			ST_DEN2: den_q <= mul_p_q[63:0];
			ST_M_ADD: npos_q[k_q] <= hsps_pkg::sat32(adv_sum);
			ST_P_LAT: begin
				pn_pos_q <= rpos;
				pn_vel_q <= rvel;
			end
			ST_P_DIF: begin
				for (int k = 0; k < 3; k++) begin
					logic signed [32:0] d, dv;
					d  = $signed({pn_pos_q[k][31], pn_pos_q[k]}) - $signed({rpos[k][31], rpos[k]});
					dv = $signed({pn_vel_q[k][31], pn_vel_q[k]}) - $signed({rvel[k][31], rvel[k]});
					ad_q[k]  <= hsps_pkg::mag33(d);
					dn_q[k]  <= d[32];
					adv_q[k] <= hsps_pkg::mag33(dv);
					dvn_q[k] <= dv[32];
				end
				vm_q   <= rvel;
				dist_q <= '0;
				dot_q  <= '0;
			end
			ST_P_SQA: dist_q <= hsps_pkg::sat_add64(dist_q, mul_p_q[63:0]);
			ST_P_DOTA: begin
				if (dn_q[k_q] != dvn_q[k_q]) dot_q <= dot_q - {1'b0, mul_p_q};
				else dot_q <= dot_q + {1'b0, mul_p_q};
			end
			ST_P_MAG: begin
				logic [66:0] m;
				m = dot_q[66] ? (~dot_q + 67'd1) : dot_q;
				dneg_q <= dot_q[66];
				dmag_q <= m[65:0];
			end
			ST_P_MHI: lo_q <= mul_p_q[63:0];
			ST_P_UPD: begin
				pn_vel_q[k_q] <= hsps_pkg::sat32(pn_new);
				vm_q[k_q]     <= hsps_pkg::sat32(vm_new);
			end
			default: ;
		endcase
	end
endmodule

@@ sv/hard_sphere_particle_step_top.sv @@
// Top level of the hard sphere step block: configuration registers, particle RAMs,
// divider and sequencer. Depends on hsps_pkg, hsps_ram, hsps_div, hsps_ctrl.
`timescale 1ns / 1ps
// Usage
//  s_* channel: one beat per item; s_tuser carries op (write, step, read).
//  m_* channel: exactly one result beat per item, in order.
//  cfg_* channel: register writes, always ready; write only while idle.
//  Particles live in two RAMs (positions, velocities), 96 bits per entry,
//  one read and one write port each; the read data is registered.
// Sequence
//  write, read or unknown op: the item goes straight to ST_DONE, which loads the result beat.
//  step: a motion and wall pass over the live particles, then a pass over every pair,
//  with three divisions by 4R^2 in the serial divider for each colliding pair, one
//  per axis, each waiting until the divider is no longer busy.
//  One item is in work at a time; s_tready is high only while idle.
// Reset
//  arst_n clears control, collision count and configuration to defaults;
//  RAM contents are undefined until written.
// Stall
//  The result register holds a beat until taken; a new item can be accepted
//  while it waits, and its own result waits for the register to drain.
module hard_sphere_particle_step_top #(
	parameter int MAX_PARTICLES = hsps_pkg::MAX_PARTICLES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser,   // op
	input  logic [199:0] s_tdata,   // particle_index, in_pos_x/y/z, in_vel_x/y/z, pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [231:0] m_tdata,   // out_index, out_pos_x/y/z, out_vel_x/y/z,
	                                // collisions_so_far, pad
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

	hsps_pkg::cfg_t     cfg_q;
	hsps_pkg::div_req_t div_req;
	hsps_pkg::div_rsp_t div_rsp;

	logic                       pos_we, vel_we, rd_en;
	logic [IDX_W-1:0]           wr_addr, rd_addr;
	logic [hsps_pkg::VEC_W-1:0] pos_wdata, vel_wdata, pos_rdata, vel_rdata;

	assign cfg_ready = 1'b1;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_use <= 7'd64;
			cfg_q.box_w  <= '0;
			cfg_q.box_h  <= '0;
			cfg_q.box_d  <= '0;
			cfg_q.radius <= 31'd65536;
			cfg_q.dt     <= 32'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hsps_pkg::CFG_IN_USE: cfg_q.in_use <= cfg_data[6:0];
				hsps_pkg::CFG_BOX_W:  cfg_q.box_w  <= cfg_data[30:0];
				hsps_pkg::CFG_BOX_H:  cfg_q.box_h  <= cfg_data[30:0];
				hsps_pkg::CFG_BOX_D:  cfg_q.box_d  <= cfg_data[30:0];
				hsps_pkg::CFG_RADIUS: cfg_q.radius <= cfg_data[30:0];
				hsps_pkg::CFG_DT:     cfg_q.dt     <= cfg_data;
				default: ;
			endcase
		end
	end

	// positions {z,y,x}
	hsps_ram #(.WIDTH(hsps_pkg::VEC_W), .DEPTH(MAX_PARTICLES)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(wr_addr), .wdata(pos_wdata),
		.re(rd_en), .raddr(rd_addr), .rdata(pos_rdata)
	);

	// velocities {z,y,x}
	hsps_ram #(.WIDTH(hsps_pkg::VEC_W), .DEPTH(MAX_PARTICLES)) u_vel_ram (
		.clk(clk), .we(vel_we), .waddr(wr_addr), .wdata(vel_wdata),
		.re(rd_en), .raddr(rd_addr), .rdata(vel_rdata)
	);

	hsps_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	hsps_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.pos_we(pos_we), .vel_we(vel_we), .wr_addr(wr_addr),
		.pos_wdata(pos_wdata), .vel_wdata(vel_wdata),
		.rd_en(rd_en), .rd_addr(rd_addr), .pos_rdata(pos_rdata), .vel_rdata(vel_rdata),
		.div_req(div_req), .div_rsp(div_rsp)
	);
endmodule

@@ sv/hsps_chk.sv @@
// Port-level checker for the hard sphere step block, bound to the top level.
// Depends on hard_sphere_particle_step_top_macros.svh.
`timescale 1ns / 1ps
`include "hard_sphere_particle_step_top_macros.svh"
module hsps_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [231:0] m_tdata
);
	// one item in work at a time
	`HSPS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// a result never appears the cycle right after its item is taken
	`HSPS_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid))
	// stalled result beat holds its payload
	`HSPS_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, $stable(m_tdata))
endmodule

bind hard_sphere_particle_step_top hsps_chk u_hsps_chk (.*);

@@ dv/tb_hard_sphere_particle_step_top.sv @@
// Testbench for hard_sphere_particle_step_top: directed rows, then random traffic per config phase.
// Results are checked against an in-bench Q16.16 particle predictor; depends on hsps_pkg.
`timescale 1ns / 1ps
module tb_hard_sphere_particle_step_top;
	localparam logic [1:0] OP_NONE = 2'd3;   // unused op code, changes nothing
	localparam int LIMIT = 20000000;         // cycle budget for the whole run

	typedef struct packed {
		logic [1:0]  op;
		logic [5:0]  idx;
		logic [31:0] px, py, pz, vx, vy, vz;
	} item_t;

	typedef struct {
		item_t       it;
		bit          typed;  // expected result given by hand
		logic [229:0] want;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0, cfg_valid = 0;
	logic [1:0] s_tuser = '0;
	logic [199:0] s_tdata = '0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_tready, m_tvalid, cfg_ready;
	logic [231:0] m_tdata;

	hard_sphere_particle_step_top dut (.*);

	always #6 clk = ~clk;

	// ---------------- predictor state ----------------
	logic signed [31:0] pos_mem [3][64];
	logic signed [31:0] vel_mem [3][64];
	logic [31:0] hit_count;
	logic [6:0]  in_use_r;
	logic [30:0] box_r [3];
	logic [30:0] radius_r;
	logic [31:0] dt_r;
	bit written [64];

	logic [229:0] result_q [$];  // expected result beats, oldest first
	int errors = 0;
	int cycles = 0;

	function automatic logic signed [31:0] clip32(input longint signed x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] drift(input logic signed [31:0] p, v);
		longint signed prod;
		prod = longint'(v) * longint'({32'd0, dt_r});
		return clip32(longint'(p) + prod / 64'sd65536);
	endfunction

	function automatic bit off_wall(input logic signed [31:0] p, input logic [30:0] box);
		longint signed half;
		half = longint'({33'd0, box} >> 1);
		return longint'(p) < -half || longint'(p) > half;
	endfunction

	// elastic exchange for one pair when the spheres overlap
	function automatic void collide(input int n, m);
		longint signed d [3];
		longint signed dv, delta;
		logic [63:0] md [3];
		logic [63:0] mdv, dist2, twor, lim, den;
		logic [64:0] s;
		logic [127:0] dot, t, dmag, num, q;
		logic dneg;
		dist2 = '0;
		for (int k = 0; k < 3; k++) begin
			d[k] = longint'(pos_mem[k][n]) - longint'(pos_mem[k][m]);
			md[k] = d[k] < 0 ? -d[k] : d[k];
			s = {1'b0, dist2} + {1'b0, md[k] * md[k]};
			dist2 = s[64] ? '1 : s[63:0];
		end
		twor = {33'd0, radius_r} << 1;
		lim = twor * twor;
		if (dist2 >= lim) return;
		dot = '0;
		for (int k = 0; k < 3; k++) begin
			dv = longint'(vel_mem[k][n]) - longint'(vel_mem[k][m]);
			mdv = dv < 0 ? -dv : dv;
			t = {64'd0, md[k]} * {64'd0, mdv};
			if ((d[k] < 0) != (dv < 0)) dot = dot - t;
			else dot = dot + t;
		end
		dneg = dot[127];
		dmag = dneg ? -dot : dot;
		den = {33'd0, radius_r} * {33'd0, radius_r} * 64'd4;
		if (den != 0) begin
			for (int k = 0; k < 3; k++) begin
				num = dmag * {64'd0, md[k]};
				q = num / {64'd0, den};
				if (q > (128'd1 << 40)) q = 128'd1 << 40;
				delta = longint'(q[63:0]);
				if (dneg != (d[k] < 0)) delta = -delta;
				vel_mem[k][n] = clip32(longint'(vel_mem[k][n]) - delta);
				vel_mem[k][m] = clip32(longint'(vel_mem[k][m]) + delta);
			end
		end
		hit_count = hit_count + 32'd1;
	endfunction

	function automatic int live_count();
		return in_use_r > 64 ? 64 : int'(in_use_r);
	endfunction

	// motion, then walls, then all pairs n<m
	function automatic void advance_box();
		int cnt;
		cnt = live_count();
		for (int i = 0; i < cnt; i++)
			for (int k = 0; k < 3; k++)
				pos_mem[k][i] = drift(pos_mem[k][i], vel_mem[k][i]);
		for (int i = 0; i < cnt; i++)
			for (int k = 0; k < 3; k++)
				if (off_wall(pos_mem[k][i], box_r[k]))
					vel_mem[k][i] = clip32(-longint'(vel_mem[k][i]));
		for (int i = 0; i < cnt; i++)
			for (int j = i + 1; j < cnt; j++)
				collide(i, j);
	endfunction

	function automatic logic [229:0] pack_res(input logic [5:0] idx,
			input logic [31:0] px, py, pz, vx, vy, vz, coll);
		return {coll, vz, vy, vx, pz, py, px, idx};
	endfunction

	function automatic logic [229:0] particle_result(input item_t it);
		logic [5:0] i;
		i = it.idx;
		case (it.op)
			hsps_pkg::OP_WRITE: begin
				pos_mem[0][i] = it.px; pos_mem[1][i] = it.py; pos_mem[2][i] = it.pz;
				vel_mem[0][i] = it.vx; vel_mem[1][i] = it.vy; vel_mem[2][i] = it.vz;
			end
			hsps_pkg::OP_STEP: advance_box();
			default: ;
		endcase
		if (it.op == hsps_pkg::OP_WRITE || it.op == hsps_pkg::OP_READ)
			return pack_res(i, pos_mem[0][i], pos_mem[1][i], pos_mem[2][i],
				vel_mem[0][i], vel_mem[1][i], vel_mem[2][i], hit_count);
		return pack_res('0, '0, '0, '0, '0, '0, '0, hit_count);
	endfunction

	// ---------------- drivers ----------------
	bit calm_tx, calm_rx;  // stretches with no idling

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 13));
	endfunction

	task automatic wr_cfg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			hsps_pkg::CFG_IN_USE: in_use_r = val[6:0];
			hsps_pkg::CFG_BOX_W:  box_r[0] = val[30:0];
			hsps_pkg::CFG_BOX_H:  box_r[1] = val[30:0];
			hsps_pkg::CFG_BOX_D:  box_r[2] = val[30:0];
			hsps_pkg::CFG_RADIUS: radius_r = val[30:0];
			hsps_pkg::CFG_DT:     dt_r = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// present one beat; on acceptance predict and queue the expected result
	task automatic send(input item_t it, input bit typed, input logic [229:0] want);
		int gap;
		logic [229:0] pred;
		gap = draw_gap(calm_tx);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {2'b00, it.vz, it.vy, it.vx, it.pz, it.py, it.px, it.idx};
		do @(posedge clk); while (!s_tready);
		pred = particle_result(it);
		if (it.op == hsps_pkg::OP_WRITE) written[it.idx] = 1'b1;
		result_q.push_back(typed ? want : pred);
		if ($urandom_range(0, 15) == 0) calm_tx = $urandom_range(0, 1);
	endtask

	// stop sending and wait for every expected beat
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---------------- result checker ----------------
	string fname [8] = '{"out_index", "out_pos_x", "out_pos_y", "out_pos_z",
		"out_vel_x", "out_vel_y", "out_vel_z", "collisions_so_far"};

	initial begin
		int stall, lsb;
		logic [229:0] exp_beat;
		logic [31:0] e, g;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(calm_rx);
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (result_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				exp_beat = result_q.pop_front();
				for (int k = 0; k < 8; k++) begin
					lsb = (k == 0) ? 0 : (k == 7) ? 198 : 6 + 32 * (k - 1);
					e = 32'(exp_beat >> lsb);
					g = 32'(m_tdata[229:0] >> lsb);
					if (k == 0) begin
						e = e & 32'h3f;
						g = g & 32'h3f;
					end
					if (e !== g) begin
						$error("%s: expected %h, got %h", fname[k], e, g);
						errors++;
					end
				end
			end
			if ($urandom_range(0, 15) == 0) calm_rx = $urandom_range(0, 1);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_hard_sphere_particle_step_top: FAIL");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	function automatic item_t mk(input logic [1:0] op, input logic [5:0] idx,
			input logic [31:0] px, py, pz, vx, vy, vz);
		item_t it;
		it = '{op, idx, px, py, pz, vx, vy, vz};
		return it;
	endfunction

	function automatic logic [31:0] rnd_coord(input int span);
		if ($urandom_range(0, 7) == 0) return $urandom;  // full range, every bit
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic item_t rnd_write(input logic [5:0] idx, input int span);
		return mk(hsps_pkg::OP_WRITE, idx, rnd_coord(span), rnd_coord(span), rnd_coord(span),
			rnd_coord(32'h40000), rnd_coord(32'h40000), rnd_coord(32'h40000));
	endfunction

	row_t rows [$];

	task automatic add_row(input item_t it, input bit typed, input logic [229:0] want);
		row_t r;
		r.it = it;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endtask

	// phase settings: in_use, box w/h/d, radius, dt, coordinate span for writes
	typedef struct {
		logic [31:0] in_use, bw, bh, bd, rad, dt;
		int span;
	} phase_t;

	phase_t phases [5] = '{
		'{32'd8,   32'h0020_0000, 32'h0020_0000, 32'h0020_0000, 32'h0001_8000, 32'h0000_4000,
			32'h0010_0000},
		'{32'd127, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'hffff_ffff,
			32'h0100_0000},
		'{32'd0,   32'd0, 32'd0, 32'd0, 32'h7fff_ffff, 32'd0, 32'h0001_0000},
		'{32'd64,  32'h0040_0000, 32'h0030_0000, 32'h0020_0000, 32'h0002_0000,
			32'h0001_0000, 32'h0020_0000},
		'{32'd2,   32'h0008_0000, 32'd0, 32'h0008_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0002_0000}
	};

	initial begin
		item_t it;
		int live, pick;
		logic [5:0] idx;

		// predictor at reset
		hit_count = '0;
		in_use_r = 7'd64;
		box_r = '{31'd0, 31'd0, 31'd0};
		radius_r = 31'd65536;
		dt_r = 32'd65536;
		for (int i = 0; i < 64; i++) begin
			written[i] = 1'b0;
			for (int k = 0; k < 3; k++) begin
				pos_mem[k][i] = '0;
				vel_mem[k][i] = '0;
			end
		end
		calm_tx = 0;
		calm_rx = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// two particles for the directed part, 16-unit box
		wr_cfg(hsps_pkg::CFG_IN_USE, 32'd2);
		wr_cfg(hsps_pkg::CFG_BOX_W, 32'h0010_0000);
		wr_cfg(hsps_pkg::CFG_BOX_H, 32'h0010_0000);
		wr_cfg(hsps_pkg::CFG_BOX_D, 32'h0010_0000);
		wr_cfg(hsps_pkg::CFG_RADIUS, 32'h0001_0000);
		wr_cfg(hsps_pkg::CFG_DT, 32'h0001_0000);

		// field extremes: write echoes, read returns what was stored
		add_row(mk(hsps_pkg::OP_WRITE, 6'd0, 32'h7fffffff, 32'h80000000, 32'h0, 32'h80000000,
			32'h7fffffff, 32'hffffffff), 1, pack_res(6'd0, 32'h7fffffff, 32'h80000000,
			32'h0, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'd0));
		add_row(mk(hsps_pkg::OP_READ, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 1,
			pack_res(6'd0, 32'h7fffffff, 32'h80000000, 32'h0, 32'h80000000,
			32'h7fffffff, 32'hffffffff, 32'd0));
		add_row(mk(hsps_pkg::OP_WRITE, 6'd63, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000), 1, pack_res(6'd63, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'd0));
		add_row(mk(hsps_pkg::OP_READ, 6'd63, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff), 1, pack_res(6'd63, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'd0));
		// unknown op: all zero but the count
		add_row(mk(OP_NONE, 6'd63, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff), 1, pack_res(6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0, 32'd0));
		// head-on pair that touches after one step
		add_row(mk(hsps_pkg::OP_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
			32'h0), 1, pack_res(6'd0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
			32'd0));
		add_row(mk(hsps_pkg::OP_WRITE, 6'd1, 32'h0001_8000, 32'h0, 32'h0, 32'hffff_0000,
			32'h0, 32'h0), 1, pack_res(6'd1, 32'h0001_8000, 32'h0, 32'h0, 32'hffff_0000,
			32'h0, 32'h0, 32'd0));
		add_row(mk(hsps_pkg::OP_STEP, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0, '0);
		add_row(mk(hsps_pkg::OP_READ, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0, '0);
		add_row(mk(hsps_pkg::OP_READ, 6'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0, '0);
		// position saturation, walls, negation of the most negative velocity
		add_row(mk(hsps_pkg::OP_WRITE, 6'd0, 32'h7fff_fff0, 32'h8000_0010, 32'h0, 32'h7fffffff,
			32'h80000000, 32'h0), 0, '0);
		add_row(mk(hsps_pkg::OP_WRITE, 6'd1, 32'h8001_0000, 32'h7fff_0000, 32'h0, 32'h80000000,
			32'h7fffffff, 32'h80000000), 0, '0);
		add_row(mk(hsps_pkg::OP_STEP, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0, '0);
		add_row(mk(hsps_pkg::OP_READ, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0, '0);
		add_row(mk(hsps_pkg::OP_READ, 6'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0, '0);
		// coincident spheres: after motion the gap is exactly 2R, so the pair is not counted
		add_row(mk(hsps_pkg::OP_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0,
			32'h0), 0, '0);
		add_row(mk(hsps_pkg::OP_WRITE, 6'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0, '0);
		add_row(mk(hsps_pkg::OP_STEP, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0, '0);
		add_row(mk(hsps_pkg::OP_READ, 6'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0, '0);
		add_row(mk(OP_NONE, 6'd5, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0, '0);

		foreach (rows[r]) send(rows[r].it, rows[r].typed, rows[r].want);

		// random phases; registers only change once all beats are back
		foreach (phases[p]) begin
			drain();
			wr_cfg(hsps_pkg::CFG_IN_USE, phases[p].in_use);
			wr_cfg(hsps_pkg::CFG_BOX_W, phases[p].bw);
			wr_cfg(hsps_pkg::CFG_BOX_H, phases[p].bh);
			wr_cfg(hsps_pkg::CFG_BOX_D, phases[p].bd);
			wr_cfg(hsps_pkg::CFG_RADIUS, phases[p].rad);
			wr_cfg(hsps_pkg::CFG_DT, phases[p].dt);
			live = live_count();
			// load every particle a step will touch
			for (int i = 0; i < live; i++)
				if (!written[i])
					send(rnd_write(6'(i), phases[p].span), 0, '0);
			repeat (12) begin
				pick = $urandom_range(0, 19);
				idx = 6'($urandom_range(0, 63));
				if (live > 2 && $urandom_range(0, 1)) idx = 6'($urandom_range(0, live - 1));
				if (pick < 8 || (pick < 15 && !written[idx]))
					it = rnd_write(idx, phases[p].span);
				else if (pick < 15)
					it = mk(hsps_pkg::OP_READ, idx, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
				else if (pick < 19)
					it = mk(hsps_pkg::OP_STEP, idx, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
				else
					it = mk(OP_NONE, idx, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
				send(it, 0, '0);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_hard_sphere_particle_step_top: PASS");
		else
			$display("tb_hard_sphere_particle_step_top: FAIL");
		$finish;
	end
endmodule
